/* design/sdh_pkg.sv */
// ----------------------------------------------------------------------------
// sdh_pkg: shared types and constants for the SD SPI host controller
// Phase codes, request codes and the command frame table.
// ----------------------------------------------------------------------------
`default_nettype none
package sdh_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int WAKE_BYTES  = 8;
  localparam int BC_W        = 10;

  typedef enum logic [1:0] {
    FN_INIT  = 2'd0,
    FN_READ  = 2'd1,
    FN_WRITE = 2'd2,
    FN_BYTE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FAIL     = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  // Command stages
  localparam logic [3:0] SG_C0  = 4'd1;
  localparam logic [3:0] SG_C8  = 4'd2;
  localparam logic [3:0] SG_C58 = 4'd3;
  localparam logic [3:0] SG_C55 = 4'd4;
  localparam logic [3:0] SG_A41 = 4'd5;
  localparam logic [3:0] SG_F58 = 4'd6;
  localparam logic [3:0] SG_R17 = 4'd7;
  localparam logic [3:0] SG_W24 = 4'd8;

  localparam logic [1:0] SUB_FRAME = 2'd0;
  localparam logic [1:0] SUB_R1    = 2'd1;
  localparam logic [1:0] SUB_EXTRA = 2'd2;
  localparam logic [1:0] SUB_TAIL  = 2'd3;

  localparam logic [5:0] P_IDLE   = 6'd0;
  localparam logic [5:0] P_WAKE   = 6'd40;
  localparam logic [5:0] P_RTOKEN = 6'd41;
  localparam logic [5:0] P_RDATA  = 6'd42;
  localparam logic [5:0] P_RCRC   = 6'd43;
  localparam logic [5:0] P_WBUSY1 = 6'd44;
  localparam logic [5:0] P_WDATA  = 6'd45;
  localparam logic [5:0] P_WCRC   = 6'd46;
  localparam logic [5:0] P_WRESP  = 6'd47;
  localparam logic [5:0] P_WBUSY2 = 6'd48;

  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] DRESP_OK    = 8'hE5;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] ECHO_BYTE   = 8'hAA;

  localparam logic [0:0] CFG_POLL_LIMIT  = 1'b0;
  localparam logic [0:0] CFG_RETRY_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] block_address;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       exchange_valid;
    logic       chip_select_level;
    logic       data_wanted;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] card_response;
    logic       fast_clock;
  } out_item_t;

  // Frame byte i of a command stage
  function automatic logic [7:0] frame_byte(input logic [3:0] stage, input logic [2:0] i,
                                            input logic [31:0] addr);
    logic [7:0] b;
    b = IDLE_BYTE;
    if (i <= 3'd5) begin
      if (stage == SG_R17 || stage == SG_W24) begin
        unique case (i)
          3'd0:    b = (stage == SG_R17) ? 8'h51 : 8'h58;
          3'd1:    b = addr[31:24];
          3'd2:    b = addr[23:16];
          3'd3:    b = addr[15:8];
          3'd4:    b = addr[7:0];
          default: b = IDLE_BYTE;
        endcase
      end else begin
        unique case (stage)
          SG_C0:  b = (i == 3'd0) ? 8'h40 : (i == 3'd5) ? 8'h95 : 8'h00;
          SG_C8: begin
            unique case (i)
              3'd0:    b = 8'h48;
              3'd3:    b = 8'h01;
              3'd4:    b = ECHO_BYTE;
              3'd5:    b = 8'h87;
              default: b = 8'h00;
            endcase
          end
          SG_C58, SG_F58: b = (i == 3'd0) ? 8'h7A : (i == 3'd5) ? 8'hFD : 8'h00;
          SG_C55: b = (i == 3'd0) ? 8'h77 : (i == 3'd5) ? 8'h65 : 8'h00;
          SG_A41: b = (i == 3'd0) ? 8'h69 : (i == 3'd1) ? 8'h40 :
                      (i == 3'd5) ? 8'h77 : 8'h00;
          default: b = IDLE_BYTE;
        endcase
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

/* design/sdh_stream_if.sv */
// ----------------------------------------------------------------------------
// sdh_stream_if: valid/ready channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface sdh_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/sdh_ctrl.sv */
// ----------------------------------------------------------------------------
// sdh_ctrl: protocol sequencer
// State registers plus next-state and result logic for one input item.
// ----------------------------------------------------------------------------
`default_nettype none
module sdh_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire sdh_pkg::in_item_t item,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_idx,
  input  wire logic [15:0]       cfg_data,
  output sdh_pkg::out_item_t     res
);
  import sdh_pkg::*;

  logic [5:0]      phase_r, phase_nxt;
  logic [2:0]      fidx_r, fidx_nxt;
  logic [BC_W-1:0] bc_r, bc_nxt;
  logic [15:0]     poll_r, poll_nxt, retry_r, retry_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic [7:0]      resp_r, resp_nxt;
  logic            sel_r, sel_nxt, fast_r, fast_nxt;
  logic [15:0]     plim_r, rlim_r;

  logic [3:0]  stage;
  logic [1:0]  sub;
  logic [15:0] poll_inc, retry_inc;
  logic        ok, r1_ok, r1_le1;
  logic [7:0]  miso;

  // Limits: zero acts as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plim_r <= 16'hFFFF;
      rlim_r <= 16'hFFFF;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_POLL_LIMIT) plim_r <= cfg_data;
      else rlim_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      fidx_r  <= '0;
      bc_r    <= '0;
      poll_r  <= '0;
      retry_r <= '0;
      addr_r  <= '0;
      resp_r  <= IDLE_BYTE;
      sel_r   <= 1'b1;
      fast_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      fidx_r  <= fidx_nxt;
      bc_r    <= bc_nxt;
      poll_r  <= poll_nxt;
      retry_r <= retry_nxt;
      addr_r  <= addr_nxt;
      resp_r  <= resp_nxt;
      sel_r   <= sel_nxt;
      fast_r  <= fast_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r; fidx_nxt = fidx_r; bc_nxt = bc_r; poll_nxt = poll_r;
    retry_nxt = retry_r; addr_nxt = addr_r; resp_nxt = resp_r; sel_nxt = sel_r;
    fast_nxt = fast_r;
    res = '0;
    res.mosi_byte = IDLE_BYTE;
    stage = phase_r[5:2];
    sub = phase_r[1:0];
    miso = item.miso_byte;
    poll_inc = poll_r + 16'd1;
    retry_inc = retry_r + 16'd1;
    ok = (fidx_r != 3'd0);
    r1_ok = 1'b0;
    r1_le1 = (miso <= 8'd1);

    priority if (item.func == FN_INIT) begin
      fast_nxt = 1'b0; sel_nxt = 1'b1; phase_nxt = P_WAKE; bc_nxt = BC_W'(1);
      res.exchange_valid = 1'b1;
    end else if (item.func == FN_READ || item.func == FN_WRITE) begin
      addr_nxt = item.block_address; sel_nxt = 1'b0;
      phase_nxt = {(item.func == FN_READ) ? SG_R17 : SG_W24, SUB_FRAME};
      fidx_nxt = 3'd1;
      res.exchange_valid = 1'b1;
      res.mosi_byte = (item.func == FN_READ) ? 8'h51 : 8'h58;
    end else if (phase_r == P_IDLE) begin
      res.exchange_valid = 1'b0;
    end else if (phase_r < P_WAKE) begin
      res.exchange_valid = 1'b1;
      unique case (sub)
        SUB_FRAME: begin
          if (fidx_r < 3'd6) begin
            res.mosi_byte = frame_byte(stage, fidx_r, addr_r);
            fidx_nxt = fidx_r + 3'd1;
          end else begin
            phase_nxt = {stage, SUB_R1}; poll_nxt = '0;
          end
        end
        SUB_R1: begin
          resp_nxt = miso;
          poll_nxt = poll_inc;
          if (r1_le1 || poll_inc >= plim_r) begin
            if (stage == SG_R17) begin
              if (miso != 8'd0) begin
                res.exchange_valid = 1'b0; res.done_res = 1'b1;
                res.status = ST_REJECTED; sel_nxt = 1'b1; phase_nxt = P_IDLE;
              end else begin
                phase_nxt = P_RTOKEN; poll_nxt = '0;
              end
            end else if (stage == SG_W24) begin
              if (miso != 8'd0) begin
                res.exchange_valid = 1'b0; res.done_res = 1'b1;
                res.status = ST_FAIL; sel_nxt = 1'b1; phase_nxt = P_IDLE;
              end else begin
                phase_nxt = P_WBUSY1; poll_nxt = '0;
              end
            end else begin
              unique case (stage)
                SG_C0:          r1_ok = (miso == 8'd1);
                SG_A41:         r1_ok = (miso == 8'd0);
                SG_C55, SG_F58: r1_ok = 1'b1;
                default:        r1_ok = r1_le1;
              endcase
              fidx_nxt = {2'b00, r1_ok};
              if ((stage == SG_C8 || stage == SG_C58 || stage == SG_F58) && r1_le1) begin
                phase_nxt = {stage, SUB_EXTRA}; bc_nxt = '0;
              end else begin
                phase_nxt = {stage, SUB_TAIL};
              end
            end
          end
        end
        SUB_EXTRA: begin
          bc_nxt = bc_r + BC_W'(1);
          if (bc_r >= BC_W'(3)) begin
            if (stage == SG_C8) fidx_nxt = {2'b00, miso == ECHO_BYTE};
            phase_nxt = {stage, SUB_TAIL};
          end
        end
        SUB_TAIL: begin
          if (stage == SG_F58 || (stage != SG_C55 && stage != SG_A41 && !ok &&
              stage != SG_C0 && stage != SG_C8 && stage != SG_C58)) begin
            fast_nxt = 1'b1; res.exchange_valid = 1'b0; res.done_res = 1'b1;
            res.status = ST_OK; sel_nxt = 1'b1; phase_nxt = P_IDLE;
          end else if (stage == SG_C55 || ok) begin
            if (stage == SG_C58) retry_nxt = '0;
            phase_nxt = {stage + 4'd1, SUB_FRAME}; fidx_nxt = 3'd1;
            res.mosi_byte = frame_byte(stage + 4'd1, 3'd0, addr_r);
          end else if (stage == SG_A41 && retry_inc < rlim_r) begin
            retry_nxt = retry_inc;
            phase_nxt = {SG_C55, SUB_FRAME}; fidx_nxt = 3'd1;
            res.mosi_byte = frame_byte(SG_C55, 3'd0, addr_r);
          end else begin
            if (stage == SG_A41) retry_nxt = retry_inc;
            res.exchange_valid = 1'b0; res.done_res = 1'b1;
            res.status = ST_FAIL; sel_nxt = 1'b1; phase_nxt = P_IDLE;
          end
        end
        default: ;
      endcase
    end else begin
      res.exchange_valid = 1'b1;
      unique case (phase_r)
        P_WAKE: begin
          if (bc_r < BC_W'(WAKE_BYTES)) bc_nxt = bc_r + BC_W'(1);
          else begin
            sel_nxt = 1'b0; phase_nxt = {SG_C0, SUB_FRAME}; fidx_nxt = 3'd1;
            res.mosi_byte = frame_byte(SG_C0, 3'd0, addr_r);
          end
        end
        P_RTOKEN: begin
          poll_nxt = poll_inc;
          if (miso == TOKEN_START) begin
            phase_nxt = P_RDATA; bc_nxt = '0;
          end else if (poll_inc >= plim_r) begin
            res.exchange_valid = 1'b0; res.done_res = 1'b1;
            res.status = ST_FAIL; sel_nxt = 1'b1; phase_nxt = P_IDLE;
          end
        end
        P_RDATA: begin
          res.read_byte = miso; res.read_valid = 1'b1;
          if ({1'b0, bc_r} + 11'd1 >= 11'(BLOCK_BYTES)) begin
            phase_nxt = P_RCRC; bc_nxt = '0;
          end else bc_nxt = bc_r + BC_W'(1);
        end
        P_RCRC: begin
          bc_nxt = bc_r + BC_W'(1);
          if (bc_r >= BC_W'(1)) begin
            res.exchange_valid = 1'b0; res.done_res = 1'b1;
            res.status = ST_OK; sel_nxt = 1'b1; phase_nxt = P_IDLE;
          end
        end
        P_WBUSY1: begin
          poll_nxt = poll_inc;
          if (miso == IDLE_BYTE || poll_inc >= plim_r) begin
            phase_nxt = P_WDATA; bc_nxt = '0;
            res.mosi_byte = TOKEN_START; res.data_wanted = 1'b1;
          end
        end
        P_WDATA: begin
          res.mosi_byte = item.write_byte;
          if ({1'b0, bc_r} + 11'd1 >= 11'(BLOCK_BYTES)) begin
            phase_nxt = P_WCRC; bc_nxt = '0;
          end else begin
            bc_nxt = bc_r + BC_W'(1); res.data_wanted = 1'b1;
          end
        end
        P_WCRC: begin
          bc_nxt = bc_r + BC_W'(1);
          if (bc_r >= BC_W'(2)) phase_nxt = P_WRESP;
        end
        P_WRESP: begin
          if (miso != DRESP_OK) begin
            res.exchange_valid = 1'b0; res.done_res = 1'b1;
            res.status = ST_FAIL; sel_nxt = 1'b1; phase_nxt = P_IDLE;
          end else begin
            phase_nxt = P_WBUSY2; poll_nxt = '0;
          end
        end
        P_WBUSY2: begin
          poll_nxt = poll_inc;
          if (miso == IDLE_BYTE || poll_inc >= plim_r) begin
            res.exchange_valid = 1'b0; res.done_res = 1'b1;
            res.status = ST_OK; sel_nxt = 1'b1; phase_nxt = P_IDLE;
          end
        end
        default: begin
          res.exchange_valid = 1'b0; phase_nxt = P_IDLE;
        end
      endcase
    end
    res.chip_select_level = sel_nxt;
    res.card_response = resp_nxt;
    res.fast_clock = fast_nxt;
  end

  a_done_deselects: assert property (@(posedge clk) disable iff (!rst_n)
    res.done_res |-> res.chip_select_level) else $error("done without deselect");
  a_done_no_xchg: assert property (@(posedge clk) disable iff (!rst_n)
    res.done_res |-> !res.exchange_valid) else $error("done with exchange");
  a_read_not_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.read_valid && res.data_wanted)) else $error("read and write data at once");
endmodule
`default_nettype wire

/* design/sd_spi_host_controller_unit.sv */
// ----------------------------------------------------------------------------
// sd_spi_host_controller_unit: SD card SPI-mode host, byte level
// Input register, sequencer and result register.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel: one transfer per request (init, read, write) or per SPI
//       byte exchanged (func 3 carries the MISO byte; write data rides
//       along when the last result asked for it).
//   out channel: exactly one result transfer per input transfer, giving
//       the next MOSI byte, chip select, read data and completion status.
//   cfg port: poll_limit (index 0) and init_retry_limit (index 1); write
//       only while idle.
// Path: an input transfer is registered, the sequencer decides
//   combinationally on it and the result is registered.
// Throughput: one transfer per cycle while out is ready; the sequencer's single state
//   update per item sets that figure.
// Reset: sync active-low; state back to idle, card deselected, fast clock
//   off, both limits at 65535.
// Stall: when out is not ready the result waits in the output register;
//   the input register takes a transfer only if empty, then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
module sd_spi_host_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sdh_stream_if.sink       in_ch,
  sdh_stream_if.source     out_ch,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_idx,
  input  wire logic [15:0] cfg_data
);
  import sdh_pkg::*;

  in_item_t  in_r;
  logic      in_v_r;
  out_item_t out_r, res;
  logic      out_v_r;
  logic      step;

  // the sequencer advances when an item is held and the result register can take its output
  assign step = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || step;
  assign out_ch.valid = out_v_r;
  assign out_ch.data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_v_r <= in_ch.valid;
      if (step) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_r <= in_ch.data;
    if (step) out_r <= res;
  end

  sdh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (in_r),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .res      (res)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r) else $error("result dropped");
  a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> in_v_r) else $error("step without item");
  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r) else $error("result not registered");
endmodule
`default_nettype wire
